// ===== hdl/radio_frame_checker_ack_defines.svh =====
// Assertion macros for the radio frame checker
`ifndef RADIO_FRAME_CHECKER_ACK_DEFINES_SVH
`define RADIO_FRAME_CHECKER_ACK_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RFCA_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`define RFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RFCA_ASSERT_NEVER(lbl, expr, msg)
`define RFCA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/rfca_pkg.sv =====
// Shared types and constants for the radio frame checker
package rfca_pkg;
    localparam int MAX_FRAME = 64;
    localparam int ID_BYTES = 8;
    localparam int HDR_BYTES = 3;
    localparam int POS_W = $clog2(MAX_FRAME + 1);
    localparam int ID_IDX_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
    localparam int COUNT_W = 7;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] TAG_LEGACY = 8'h44;
    localparam logic [7:0] TAG_V2 = 8'h45;

    localparam logic [2:0] VERDICT_ACCEPT = 3'd0;
    localparam logic [2:0] VERDICT_ADDRESS = 3'd1;
    localparam logic [2:0] VERDICT_TAG = 3'd2;
    localparam logic [2:0] VERDICT_CHECKSUM = 3'd3;
    localparam logic [2:0] VERDICT_FACTORY = 3'd4;
    localparam logic [2:0] VERDICT_SHORT = 3'd5;
    localparam logic [2:0] VERDICT_LONG = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic CFG_NODE_ADDRESS = 1'b0;
    localparam logic CFG_FACTORY_ID = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [7:0]         payload_byte;
        logic [2:0]         verdict;
        logic [7:0]         ack_destination;
        logic [7:0]         ack_source;
        logic [7:0]         ack_check;
        logic [COUNT_W-1:0] payload_count;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result item;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;
endpackage

// ===== hdl/rfca_front.sv =====
// Front end: frame state, header and checksum checks, result generation
module rfca_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic [7:0]          i_node_address,
    input  logic [63:0]         i_own_id,
    input  rfca_pkg::t_q_status i_q_status,
    output logic                o_ready,
    output rfca_pkg::t_push     o_push
);
    import rfca_pkg::*;

    logic [POS_W-1:0]    r_pos, n_pos;
    logic [7:0]          r_xor, n_xor;
    logic [7:0]          r_dest, n_dest;
    logic [7:0]          r_tag, n_tag;
    logic [7:0]          r_src, n_src;
    logic                r_id_ok, n_id_ok;
    logic [7:0]          r_prev, n_prev;
    logic                r_over, n_over;

    logic                accept;
    logic                in_range;
    logic                is_v2;
    logic                known;
    logic [POS_W-1:0]    start;
    logic                id_win;
    logic [ID_IDX_W-1:0] id_k;
    logic [5:0]          id_sh;
    logic [7:0]          id_byte;
    logic                id_ok_now;
    logic                dest_ok;
    logic                over;
    logic [POS_W-1:0]    lastp;
    logic [POS_W-1:0]    count;
    logic [2:0]          verdict;

    assign o_ready  = !i_q_status.full;
    assign accept   = i_valid && o_ready;
    assign in_range = r_pos < POS_W'(MAX_FRAME);
    assign is_v2    = r_tag == TAG_V2;
    assign known    = is_v2 || (r_tag == TAG_LEGACY);
    assign start    = is_v2 ? POS_W'(HDR_BYTES + ID_BYTES) : POS_W'(HDR_BYTES);
    assign dest_ok  = r_dest == i_node_address;

    assign id_win  = is_v2 && (r_pos >= POS_W'(HDR_BYTES))
                     && (r_pos < POS_W'(HDR_BYTES + ID_BYTES));
    assign id_k    = ID_IDX_W'(r_pos - POS_W'(HDR_BYTES));
    assign id_sh   = 6'((ID_BYTES - 1 - int'(id_k)) * 8);
    assign id_byte = 8'(i_own_id >> id_sh);
    assign id_ok_now = r_id_ok && !(id_win && (id_byte != i_byte));

    // verdict side
    assign over  = r_over || !in_range;
    assign lastp = over ? POS_W'(MAX_FRAME - 1) : (r_pos - POS_W'(1));
    always_comb begin
        count = '0;
        if (dest_ok && known && (!is_v2 || r_id_ok) && (r_pos >= POS_W'(2))
            && (lastp > start)) begin
            count = lastp - start;
        end
        if (over) begin
            verdict = VERDICT_LONG;
        end else if (r_pos < POS_W'(2)) begin
            verdict = VERDICT_SHORT;
        end else if (!dest_ok) begin
            verdict = VERDICT_ADDRESS;
        end else if (!known) begin
            verdict = VERDICT_TAG;
        end else if (r_pos <= start) begin
            verdict = VERDICT_SHORT;
        end else if (r_xor != i_byte) begin
            verdict = VERDICT_CHECKSUM;
        end else if (is_v2 && !r_id_ok) begin
            verdict = VERDICT_FACTORY;
        end else begin
            verdict = VERDICT_ACCEPT;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_xor   = r_xor;
        n_dest  = r_dest;
        n_tag   = r_tag;
        n_src   = r_src;
        n_id_ok = r_id_ok;
        n_prev  = r_prev;
        n_over  = r_over;
        o_push  = '0;
        if (accept) begin
            if (i_last) begin
                o_push.valid                = 1'b1;
                o_push.item.kind            = KIND_VERDICT;
                o_push.item.verdict         = verdict;
                o_push.item.ack_destination = r_src;
                o_push.item.ack_source      = r_dest;
                o_push.item.ack_check       = i_byte;
                o_push.item.payload_count   = COUNT_W'(count);
                n_pos   = '0;
                n_xor   = '0;
                n_dest  = '0;
                n_tag   = '0;
                n_src   = '0;
                n_id_ok = 1'b1;
                n_prev  = '0;
                n_over  = 1'b0;
            end else if (!in_range) begin
                n_over = 1'b1;
            end else begin
                if (r_pos == POS_W'(0)) begin
                    n_dest = i_byte;
                end else if (r_pos == POS_W'(1)) begin
                    n_tag = i_byte;
                end else begin
                    if (r_pos == POS_W'(2)) begin
                        n_src = i_byte;
                    end
                    n_xor   = r_xor ^ i_byte;
                    n_id_ok = id_ok_now;
                    if (dest_ok && known && (!is_v2 || id_ok_now) && (r_pos > start)) begin
                        o_push.valid             = 1'b1;
                        o_push.item.kind         = KIND_PAYLOAD;
                        o_push.item.payload_byte = r_prev;
                    end
                end
                n_prev = i_byte;
                n_pos  = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_xor   <= '0;
            r_dest  <= '0;
            r_tag   <= '0;
            r_src   <= '0;
            r_id_ok <= 1'b1;
            r_prev  <= '0;
            r_over  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_xor   <= n_xor;
            r_dest  <= n_dest;
            r_tag   <= n_tag;
            r_src   <= n_src;
            r_id_ok <= n_id_ok;
            r_prev  <= n_prev;
            r_over  <= n_over;
        end
    end
endmodule

// ===== hdl/rfca_queue.sv =====
// Short result queue between front end and output stage
module rfca_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rfca_pkg::t_push     i_push,
    input  logic                i_pop,
    output rfca_pkg::t_result   o_head,
    output rfca_pkg::t_q_status o_status
);
    import rfca_pkg::*;

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, n_wr;
    logic [Q_PTR_W-1:0]   r_rd, n_rd;
    logic [Q_CNT_W-1:0]   r_cnt, n_cnt;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = r_cnt == Q_CNT_W'(Q_DEPTH);
    assign o_status.empty = r_cnt == '0;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.valid) begin
            n_wr = r_wr + Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + Q_PTR_W'(1);
        end
        case ({i_push.valid, i_pop})
            2'b10:   n_cnt = r_cnt + Q_CNT_W'(1);
            2'b01:   n_cnt = r_cnt - Q_CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end
endmodule

// ===== hdl/rfca_back.sv =====
// Output stage: register that presents queued results to the sink
module rfca_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rfca_pkg::t_q_status i_status,
    input  rfca_pkg::t_result   i_head,
    input  logic                i_tready,
    output logic                o_pop,
    output logic                o_tvalid,
    output rfca_pkg::t_result   o_item
);
    import rfca_pkg::*;

    logic    r_valid;
    t_result r_item;

    assign o_pop    = !i_status.empty && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
    end
endmodule

// ===== hdl/radio_frame_checker_ack.sv =====
// Top level of the radio frame checker: config registers and stage wiring
//
// Receives a radio frame one byte per word (tlast on the checksum byte),
// checks destination, tag, factory id, length and XOR checksum, forwards
// payload bytes held back by one word and ends each frame with one verdict
// word carrying the ACK fields. One byte is taken every clock cycle
// while the queue is not full; results pass through the front end, the
// four-entry queue and the output register. Input tready drops only
// while the queue is full, i.e. after the sink has stalled.
`include "radio_frame_checker_ack_defines.svh"
module radio_frame_checker_ack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // end_of_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [10:8] verdict, [18:11] ack_destination,
    // [26:19] ack_source, [34:27] ack_check, [41:35] payload_count, rest 0
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,   // result_kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import rfca_pkg::*;

    logic [7:0]  r_node_address;
    logic [63:0] r_own_id;

    t_push       push;
    t_q_status   q_status;
    t_result     head;
    t_result     out_item;
    logic        pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= 8'hFF;
            r_own_id       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODE_ADDRESS: r_node_address <= i_cfg_data[7:0];
                CFG_FACTORY_ID:   r_own_id       <= i_cfg_data;
                default:          r_own_id       <= r_own_id;
            endcase
        end
    end

    rfca_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .i_byte         (s_axis_tdata),
        .i_last         (s_axis_tlast),
        .i_node_address (r_node_address),
        .i_own_id       (r_own_id),
        .i_q_status     (q_status),
        .o_ready        (s_axis_tready),
        .o_push         (push)
    );

    rfca_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    rfca_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (q_status),
        .i_head   (head),
        .i_tready (m_axis_tready),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .o_item   (out_item)
    );

    assign m_axis_tuser = out_item.kind;
    assign m_axis_tdata = {6'b0, out_item.payload_count, out_item.ack_check,
                           out_item.ack_source, out_item.ack_destination,
                           out_item.verdict, out_item.payload_byte};

    `RFCA_ASSERT_NEVER(a_ready_when_full, q_status.full && s_axis_tready, "ready while queue full")
    `RFCA_ASSERT_NEVER(a_full_and_empty, q_status.full && q_status.empty, "queue full and empty")
    `RFCA_ASSERT_NEXT(a_verdict_queued, s_axis_tvalid && s_axis_tready && s_axis_tlast, !q_status.empty || m_axis_tvalid, "verdict word lost")
endmodule
